FILE: sv/lever_position_scaler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lever position scaler
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEVER_POSITION_SCALER_CORE_ASSERT_SVH
`define LEVER_POSITION_SCALER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset disable
`define LPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds during reset
`define LPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPS_ASSERT(lbl, clk, rstn, prop, msg)
`define LPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Types, codes and constants shared by the lever position scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lps_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int LOGIC_BITS      = 10;
  localparam int MARGIN_BITS     = 8;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 10;

  localparam logic [LOGIC_BITS-1:0]  LOGIC_LOW_RST   = 10'd0;
  localparam logic [LOGIC_BITS-1:0]  LOGIC_HIGH_RST  = 10'd1023;
  localparam logic [LOGIC_BITS-1:0]  SPLIT_POINT_RST = 10'd512;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RST      = 8'd10;
  localparam logic [MARGIN_BITS-1:0] DEADBAND_RST    = 8'd5;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CAL    = 2'd2
  } lps_op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOGIC_LOW   = 3'd0,
    REG_LOGIC_HIGH  = 3'd1,
    REG_SPLIT_POINT = 3'd2,
    REG_MARGIN      = 3'd3,
    REG_DEADBAND    = 3'd4
  } lps_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } lps_state_e;

  typedef struct packed {
    logic [LOGIC_BITS-1:0]  logic_low;
    logic [LOGIC_BITS-1:0]  logic_high;
    logic [LOGIC_BITS-1:0]  split_point;
    logic [MARGIN_BITS-1:0] margin;
    logic [MARGIN_BITS-1:0] deadband;
  } lps_cfg_t;

endpackage

FILE: sv/lps_stream_if.sv
// ----------------------------------------------------------------------------
// lps_stream_if
// Valid/ready channels for lever sample items and scaled value items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lps_in_if #(
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface lps_out_if;
  logic                            valid;
  logic                            ready;
  logic [lps_pkg::LOGIC_BITS-1:0]  logic_value;

  modport source (output valid, output logic_value, input ready);
  modport sink   (input valid, input logic_value, output ready);
endinterface

FILE: sv/lever_position_scaler_core.sv
// ----------------------------------------------------------------------------
// lever_position_scaler_core
// Deadband, clamp and linear map of lever samples with span calibration.
// ----------------------------------------------------------------------------
// Flow: an accepted item steps through evaluate, multiply, divide and finish;
//   a degenerate span skips multiply and divide, and finish can wait on the output.
// One item at a time: a new item is accepted only in idle, after the last one is
//   done; calibrate, dropped or unused items return to idle after evaluation.
// Reset: asynchronous, active low; clears control registers, span to full range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lever_position_scaler_core_assert.svh"

module lever_position_scaler_core #(
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  lps_in_if.sink                            in_i,
  lps_out_if.source                         out_o
);

  localparam int LB = lps_pkg::LOGIC_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int NW = SB + LB;
  localparam int CW = (SB > LB) ? SB : LB;
  localparam logic [SB-1:0] SMAX = {SB{1'b1}};

  lps_pkg::lps_cfg_t   cfg;
  lps_pkg::lps_state_e state_q, state_d;

  logic [1:0]    op_q;
  logic [SB-1:0] smp_q;
  logic          armed_q;
  logic [SB-1:0] last_smp_q;
  logic [LB-1:0] last_out_q;
  logic [SB-1:0] span_lo_q;
  logic [SB-1:0] span_hi_q;
  logic [SB-1:0] xo_q;
  logic [SB-1:0] den_q;
  logic [LB-1:0] dmag_q;
  logic          neg_q;
  logic          zero_q;
  logic          out_vld_q;
  logic [LB-1:0] out_val_q;

  logic          in_ready;
  logic          accept;
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [LB-1:0] div_quot;

  // evaluation terms
  logic [SB-1:0] diff;
  logic          pass;
  logic          degen;
  logic [SB-1:0] x_clamp;
  logic          go_scale;
  logic          cal_high;
  logic [SB:0]   cal_sum;
  logic [SB-1:0] cal_hi_val;
  logic [SB-1:0] cal_lo_val;
  logic [NW-1:0] product;
  logic [LB-1:0] quot_sel;
  logic [LB-1:0] value;
  logic          emit;
  logic          slot_free;

  lps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign product = {{LB{1'b0}}, xo_q} * {{SB{1'b0}}, dmag_q};

  lps_divider #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (product),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign accept = in_i.valid && in_ready;

  always_comb begin
    diff       = (last_smp_q > smp_q) ? (last_smp_q - smp_q) : (smp_q - last_smp_q);
    pass       = armed_q && (smp_q != last_smp_q) &&
                 (diff >= {{(SB-lps_pkg::MARGIN_BITS){1'b0}}, cfg.deadband});
    degen      = (span_hi_q <= span_lo_q);
    if (smp_q > span_hi_q) begin
      x_clamp = span_hi_q;
    end else if (smp_q < span_lo_q) begin
      x_clamp = span_lo_q;
    end else begin
      x_clamp = smp_q;
    end
    go_scale   = (op_q == lps_pkg::OP_INIT) || ((op_q == lps_pkg::OP_SAMPLE) && pass);
    cal_high   = ({{(CW-SB){1'b0}}, smp_q} > {{(CW-LB){1'b0}}, cfg.split_point});
    cal_hi_val = (smp_q > {{(SB-lps_pkg::MARGIN_BITS){1'b0}}, cfg.margin}) ?
                 (smp_q - {{(SB-lps_pkg::MARGIN_BITS){1'b0}}, cfg.margin}) : '0;
    cal_sum    = {1'b0, smp_q} + {{(SB+1-lps_pkg::MARGIN_BITS){1'b0}}, cfg.margin};
    cal_lo_val = (cal_sum > {1'b0, SMAX}) ? SMAX : cal_sum[SB-1:0];
    quot_sel   = zero_q ? '0 : div_quot;
    value      = neg_q ? (cfg.logic_low - quot_sel) : (cfg.logic_low + quot_sel);
    emit       = (op_q == lps_pkg::OP_INIT) || (value != last_out_q);
    slot_free  = !out_vld_q || out_o.ready;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lps_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lps_pkg::ST_EVAL;
        end
      end
      lps_pkg::ST_EVAL: begin
        if (!go_scale) begin
          state_d = lps_pkg::ST_IDLE;
        end else if (degen) begin
          state_d = lps_pkg::ST_FINISH;
        end else begin
          state_d = lps_pkg::ST_MUL;
        end
      end
      lps_pkg::ST_MUL: state_d = lps_pkg::ST_DIV;
      lps_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lps_pkg::ST_FINISH;
        end
      end
      lps_pkg::ST_FINISH: begin
        if (!emit || slot_free) begin
          state_d = lps_pkg::ST_IDLE;
        end
      end
      default: state_d = lps_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state_q)
      lps_pkg::ST_IDLE: in_ready  = 1'b1;
      lps_pkg::ST_MUL:  div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lps_pkg::ST_IDLE;
      armed_q    <= 1'b0;
      last_smp_q <= '0;
      last_out_q <= '0;
      span_lo_q  <= '0;
      span_hi_q  <= SMAX;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lps_pkg::ST_EVAL) begin
        if (go_scale) begin
          last_smp_q <= smp_q;
        end
        if (op_q == lps_pkg::OP_INIT) begin
          armed_q <= 1'b1;
        end
        if (op_q == lps_pkg::OP_CAL) begin
          if (cal_high) begin
            span_hi_q <= cal_hi_val;
          end else begin
            span_lo_q <= cal_lo_val;
          end
        end
      end
      if ((state_q == lps_pkg::ST_FINISH) && emit && slot_free) begin
        out_vld_q  <= 1'b1;
        last_out_q <= value;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.op;
      smp_q <= in_i.sample;
    end
    if (state_q == lps_pkg::ST_EVAL) begin
      zero_q <= degen;
      xo_q   <= x_clamp - span_lo_q;
      den_q  <= span_hi_q - span_lo_q;
      neg_q  <= (cfg.logic_high < cfg.logic_low);
      dmag_q <= (cfg.logic_high < cfg.logic_low) ? (cfg.logic_low - cfg.logic_high) :
                                                   (cfg.logic_high - cfg.logic_low);
    end
    if ((state_q == lps_pkg::ST_FINISH) && emit && slot_free) begin
      out_val_q <= value;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_vld_q;
  assign out_o.logic_value = out_val_q;

  `LPS_ASSERT(a_one_item_at_a_time, clk_i, rst_ni, accept |=> !in_i.ready, "item accepted while previous still in work")
  `LPS_ASSERT(a_out_from_finish, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == lps_pkg::ST_FINISH), "result raised outside finish step")
  `LPS_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_done |-> (state_q == lps_pkg::ST_DIV), "divider finished outside divide step")
  `LPS_ASSERT(a_div_idle_outside, clk_i, rst_ni, div_busy |-> (state_q == lps_pkg::ST_DIV), "divider busy outside divide step")

endmodule

FILE: sv/lps_cfg_regs.sv
// ----------------------------------------------------------------------------
// lps_cfg_regs
// Configuration register file: logic range, split point, margin, deadband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  output lps_pkg::lps_cfg_t                   cfg_o
);

  lps_pkg::lps_cfg_t cfg_q;
  lps_pkg::lps_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lps_pkg::REG_LOGIC_LOW:   cfg_d.logic_low   = cfg_wdata_i[lps_pkg::LOGIC_BITS-1:0];
        lps_pkg::REG_LOGIC_HIGH:  cfg_d.logic_high  = cfg_wdata_i[lps_pkg::LOGIC_BITS-1:0];
        lps_pkg::REG_SPLIT_POINT: cfg_d.split_point = cfg_wdata_i[lps_pkg::LOGIC_BITS-1:0];
        lps_pkg::REG_MARGIN:      cfg_d.margin      = cfg_wdata_i[lps_pkg::MARGIN_BITS-1:0];
        lps_pkg::REG_DEADBAND:    cfg_d.deadband    = cfg_wdata_i[lps_pkg::MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.logic_low   <= lps_pkg::LOGIC_LOW_RST;
      cfg_q.logic_high  <= lps_pkg::LOGIC_HIGH_RST;
      cfg_q.split_point <= lps_pkg::SPLIT_POINT_RST;
      cfg_q.margin      <= lps_pkg::MARGIN_RST;
      cfg_q.deadband    <= lps_pkg::DEADBAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lps_divider.sv
// ----------------------------------------------------------------------------
// lps_divider
// Restoring divider, one quotient bit per cycle, for the linear map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lever_position_scaler_core_assert.svh"

module lps_divider #(
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [SAMPLE_BITS+lps_pkg::LOGIC_BITS-1:0] num_i,
  input  logic [SAMPLE_BITS-1:0]                   den_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic [lps_pkg::LOGIC_BITS-1:0]           quot_o
);

  localparam int QB = lps_pkg::LOGIC_BITS;
  localparam int NW = SAMPLE_BITS + QB;
  localparam int CB = $clog2(QB);

  logic          busy_q;
  logic          done_q;
  logic [CB-1:0] cnt_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] dsh_q;
  logic [QB-1:0] quot_q;
  logic          ge;

  // quotient is known to fit QB bits, so the divisor starts shifted by QB-1
  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CB'(QB - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= {1'b0, den_i, {(QB-1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QB-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  `LPS_ASSERT(a_no_restart, clk_i, rst_ni, start_i |-> !busy_q, "divider restarted while busy")
  `LPS_ASSERT(a_busy_ends_done, clk_i, rst_ni, (busy_q && cnt_q == '0) |=> (done_q && !busy_q), "divider did not finish after last step")

endmodule
